FILE: hw/rtl/csc_pkg.sv
// Shared constants and types of the cross stencil star counter.
package csc_pkg;

    // Configuration register widths and port geometry.
    localparam int ROW_CFG_W  = 13;
    localparam int COL_CFG_W  = 11;
    localparam int THR_W      = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Width of the star count result.
    localparam int COUNT_W = 22;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_THRESHOLD = 2'd2;

    // Register values after reset.
    localparam logic [ROW_CFG_W-1:0] ROW_COUNT_RST     = 13'd6;
    localparam logic [COL_CFG_W-1:0] COL_COUNT_RST     = 11'd8;
    localparam logic [THR_W-1:0]     AVG_THRESHOLD_RST = 8'd6;

    // Smallest frame side that is honored.
    localparam int MIN_SIZE = 3;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Classification of one word, made by the front.
    typedef struct packed {
        logic center;
        logic frame_end;
    } csc_flags_t;

    typedef logic [COUNT_W-1:0] count_t;

endpackage

FILE: hw/rtl/csc_front.sv
// Front part: tracks the raster position and classifies each accepted pixel.
module csc_front
    import csc_pkg::*;
#(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 4096,
    parameter int PIXEL_BITS = 8,
    parameter int COL_W      = 10,
    parameter int ROW_W      = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIXEL_BITS-1:0] pixel,
    input  logic [ROW_CFG_W-1:0]  row_count,
    input  logic [COL_CFG_W-1:0]  col_count,
    input  logic                  q_full,
    output logic                  q_push,
    output logic [COL_W-1:0]      q_col,
    output logic [PIXEL_BITS-1:0] q_pixel,
    output csc_flags_t            q_flags
);

    localparam int RE_W = ROW_W + 1;
    localparam int CE_W = COL_W + 1;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [RE_W-1:0]  rows_eff;
    logic [CE_W-1:0]  cols_eff;
    logic [CE_W-1:0]  col_inc;
    logic [RE_W-1:0]  row_inc;
    logic             accept;
    logic             row_end;
    logic             frame_end;

    // Frame size clamped to the range the line stores support.
    always_comb
    begin
        if (32'(row_count) < 32'(MIN_SIZE))
            rows_eff = RE_W'(MIN_SIZE);
        else if (32'(row_count) > 32'(MAX_ROWS))
            rows_eff = RE_W'(MAX_ROWS);
        else
            rows_eff = RE_W'(row_count);

        if (32'(col_count) < 32'(MIN_SIZE))
            cols_eff = CE_W'(MIN_SIZE);
        else if (32'(col_count) > 32'(MAX_COLS))
            cols_eff = CE_W'(MAX_COLS);
        else
            cols_eff = CE_W'(col_count);
    end

    // Row and frame boundaries of the current position.
    assign col_inc   = {1'b0, col_reg} + CE_W'(1);
    assign row_inc   = {1'b0, row_reg} + RE_W'(1);
    assign row_end   = (col_inc >= cols_eff);
    assign frame_end = row_end && (row_inc >= rows_eff);

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;

    // The word pushed to the queue carries its column and classification.
    assign q_push            = accept;
    assign q_col             = col_reg;
    assign q_pixel           = pixel;
    assign q_flags.center    = (row_reg >= ROW_W'(2)) && (col_reg != '0) && !row_end;
    assign q_flags.frame_end = frame_end;

    // Next raster position.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: hw/rtl/csc_queue.sv
// Short first-in first-out queue between the front and the back.
module csc_queue
    import csc_pkg::*;
#(
    parameter int W = 20
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         full,
    output logic         not_empty
);

    logic [W-1:0]      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QPTR_W+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: hw/rtl/csc_back.sv
// Back part: line stores, cross sum, threshold test, star count and result register.
module csc_back
    import csc_pkg::*;
#(
    parameter int MAX_COLS   = 1024,
    parameter int PIXEL_BITS = 8,
    parameter int COL_W      = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_ready,
    output logic                  q_pop,
    input  logic [COL_W-1:0]      q_col,
    input  logic [PIXEL_BITS-1:0] q_pixel,
    input  csc_flags_t            q_flags,
    input  logic [THR_W-1:0]      avg_threshold,
    output logic                  out_valid,
    input  logic                  out_stall,
    output count_t                star_count
);

    localparam int SUM_W = ((PIXEL_BITS > THR_W) ? PIXEL_BITS : THR_W) + 3;

    logic [PIXEL_BITS-1:0] middle_mem [MAX_COLS];
    logic [PIXEL_BITS-1:0] upper_mem  [MAX_COLS];

    logic                  advance;
    logic [COL_W-1:0]      right_addr;

    logic                  s1_valid_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    csc_flags_t            s1_flags_reg;
    logic [PIXEL_BITS-1:0] mid_rd_reg;
    logic [PIXEL_BITS-1:0] right_rd_reg;
    logic [PIXEL_BITS-1:0] up_rd_reg;
    logic [PIXEL_BITS-1:0] left_reg;

    logic [SUM_W-1:0]      sum;
    logic [SUM_W-1:0]      limit;

    logic                  s2_valid_reg;
    logic                  s2_star_reg;
    logic                  s2_frame_end_reg;

    count_t                count_reg;
    count_t                count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    count_t                star_count_reg;
    count_t                star_count_next;

    // The whole pipeline moves unless a result waits on a stalled output.
    assign advance = !out_valid_reg || !out_stall;
    assign q_pop   = advance && q_ready;

    assign right_addr = (q_col == COL_W'(MAX_COLS - 1)) ? '0 : q_col + COL_W'(1);

    // Stage one: read both line stores and store the new pixel in the middle line.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            mid_rd_reg          <= middle_mem[q_col];
            right_rd_reg        <= middle_mem[right_addr];
            up_rd_reg           <= upper_mem[q_col];
            middle_mem[q_col]   <= q_pixel;
            s1_col_reg          <= q_col;
            s1_pixel_reg        <= q_pixel;
            s1_flags_reg        <= q_flags;
        end
    end

    // The old middle value, held in stage one, moves down into the upper line when the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            upper_mem[s1_col_reg] <= mid_rd_reg;
            left_reg              <= mid_rd_reg;
        end
    end

    // Cross sum; sum / 5 > t is the same test as sum > 5 * t + 4.
    assign sum = SUM_W'(mid_rd_reg) + SUM_W'(left_reg) + SUM_W'(right_rd_reg)
               + SUM_W'(up_rd_reg) + SUM_W'(s1_pixel_reg);
    assign limit = (SUM_W'(avg_threshold) << 2) + SUM_W'(avg_threshold) + SUM_W'(4);

    // Stage two: threshold decision.
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            s2_star_reg      <= s1_flags_reg.center && (sum > limit);
            s2_frame_end_reg <= s1_flags_reg.frame_end;
        end
    end

    // Star counter and result register.
    always_comb
    begin
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        star_count_next = star_count_reg;
        if (advance && s2_valid_reg)
        begin
            if (s2_star_reg && (count_reg != '1))
                count_next = count_reg + COUNT_W'(1);
            if (s2_frame_end_reg)
            begin
                out_valid_next  = 1'b1;
                star_count_next = count_reg;
                count_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= q_ready;
                s2_valid_reg <= s1_valid_reg;
            end
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        star_count_reg <= star_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign star_count = star_count_reg;

endmodule

FILE: hw/rtl/cross_stencil_star_counter_top.sv
// Top level of the cross stencil star counter: configuration registers and the two halves.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_stall    pixel
//   output   out        out_valid / out_stall  star_count
//   config   in         cfg_write              cfg_index, cfg_data
//
// One pixel word is taken per cycle unless the input is stalled; per word the middle
// line store is read at two addresses and the upper at one, and each is written once.
// The result follows the frame's last word via the queue and stages one and two.
// Reset clears positions, counter, queue and valid flags; line stores are not cleared.
// A stall on the output halts the back; the queue then fills and stalls the input.
module cross_stencil_star_counter_top
    import csc_pkg::*;
#(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 4096,
    parameter int PIXEL_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIXEL_BITS-1:0] pixel,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COUNT_W-1:0]    star_count,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int FLAG_W = $bits(csc_flags_t);
    localparam int QW     = COL_W + PIXEL_BITS + FLAG_W;

    logic [ROW_CFG_W-1:0]  row_count_reg;
    logic [COL_CFG_W-1:0]  col_count_reg;
    logic [THR_W-1:0]      avg_threshold_reg;

    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_not_empty;
    logic [COL_W-1:0]      push_col;
    logic [PIXEL_BITS-1:0] push_pixel;
    csc_flags_t            push_flags;
    logic [QW-1:0]         pop_word;
    logic [COL_W-1:0]      pop_col;
    logic [PIXEL_BITS-1:0] pop_pixel;
    csc_flags_t            pop_flags;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg     <= ROW_COUNT_RST;
            col_count_reg     <= COL_COUNT_RST;
            avg_threshold_reg <= AVG_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ROW_COUNT:     row_count_reg     <= cfg_data[ROW_CFG_W-1:0];
                REG_COL_COUNT:     col_count_reg     <= cfg_data[COL_CFG_W-1:0];
                REG_AVG_THRESHOLD: avg_threshold_reg <= cfg_data[THR_W-1:0];
                default:           ;
            endcase
        end
    end

    csc_front #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .PIXEL_BITS (PIXEL_BITS),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .row_count (row_count_reg),
        .col_count (col_count_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_col     (push_col),
        .q_pixel   (push_pixel),
        .q_flags   (push_flags)
    );

    csc_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_col, push_pixel, push_flags}),
        .pop       (q_pop),
        .pop_data  (pop_word),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    // Unpack the queue head.
    assign pop_col   = pop_word[QW-1 -: COL_W];
    assign pop_pixel = pop_word[FLAG_W +: PIXEL_BITS];
    assign pop_flags = pop_word[FLAG_W-1:0];

    csc_back #(
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS),
        .COL_W      (COL_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_ready       (q_not_empty),
        .q_pop         (q_pop),
        .q_col         (pop_col),
        .q_pixel       (pop_pixel),
        .q_flags       (pop_flags),
        .avg_threshold (avg_threshold_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .star_count    (star_count)
    );

endmodule

FILE: hw/rtl/csc_checker.sv
// Port-level checks of the cross stencil star counter and their attachment to the top level.
module csc_checker
    import csc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [COUNT_W-1:0] star_count
);

    // A result word that is stalled stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

    // A stalled result word keeps its count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(star_count))
    else $error("stalled result word changed");

    // Once reset has been seen at an edge, no result word is offered at the next one.
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
    else $error("result word offered during reset");

    // The input only backs up when a result word is held on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
    else $error("input stalled without a held result word");

endmodule

bind cross_stencil_star_counter_top csc_checker u_checker (.*);
